// File: hw/rtl/ecf_pkg.sv
// Package for the Eulerian circuit finder.
// Holds the sequencer state type, status codes and color constants; no dependencies.
package ecf_pkg;

   localparam int COLOR_W       = 6;
   localparam int MAX_COLOR     = 63;
   localparam int NUM_COLORS    = MAX_COLOR + 1;
   localparam int DEF_MAX_EDGES = 64;

   localparam logic [1:0] ST_TOUR     = 2'd0;
   localparam logic [1:0] ST_LOST     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_EVAL,
      S_RESTORE,
      S_CHECK,
      S_OUT_FIRST,
      S_OUT_RD,
      S_OUT_LD,
      S_RESP
   } state_type;

endpackage

// File: hw/rtl/euler_circuit_finder.sv
// Eulerian circuit finder top level: bead load, Hierholzer walk and tour output.
// Depends on ecf_pkg.
//
//   channel   ports                                       direction
//   request   req_valid req_ready req_op req_color_a/b    in
//   response  rsp_valid rsp_ready rsp_status rsp_from_color
//             rsp_to_color rsp_last                       out
//
// A bead load is taken in S_IDLE; loads go back to back while idle.
// End of case: an overflow, empty or odd-degree status is offered in the cycle after
// the end beat. A walk visits S_FETCH, S_EVAL per edge-store probe (registered read of
// the single edge memory port), S_FETCH, S_RESTORE per pop, then S_OUT_RD, S_OUT_LD,
// S_RESP per tour beat (read, load, handshake); the edge scan loop sets the length.
// Synchronous active-high reset clears all case state; no clearing pass is needed.
// A stalled response beat holds the sequencer; no request is taken until the case ends.
module euler_circuit_finder
   import ecf_pkg::*;
#(
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [COLOR_W-1:0] req_color_a,
   input  logic [COLOR_W-1:0] req_color_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [COLOR_W-1:0] rsp_from_color,
   output logic [COLOR_W-1:0] rsp_to_color,
   output logic               rsp_last
);

   localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int SI_W  = $clog2(MAX_EDGES + 1);
   localparam int CNT_W = $clog2(MAX_EDGES + 2);
   localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_EDGES);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic [NUM_COLORS-1:0]   parity_ff, parity_in;
   logic [COLOR_W-1:0]      start_ff, start_in;
   logic [MAX_EDGES-1:0]    used_ff, used_in;
   logic [COLOR_W-1:0]      here_ff, here_in;
   logic [CNT_W-1:0]        j_ff, j_in;
   logic [CNT_W-1:0]        sp_ff, sp_in;
   logic [CNT_W-1:0]        len_ff, len_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [COLOR_W-1:0]      prev_ff, prev_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [COLOR_W-1:0]      rsp_from_ff, rsp_from_in;
   logic [COLOR_W-1:0]      rsp_to_ff, rsp_to_in;
   logic                    rsp_last_ff, rsp_last_in;

   // memories
   logic [2*COLOR_W-1:0]       edge_mem [MAX_EDGES];
   logic [2*COLOR_W-1:0]       edge_rd_ff;
   logic                       edge_we;
   logic [COLOR_W+CNT_W-1:0]   stack_mem [MAX_EDGES+1];
   logic [COLOR_W+CNT_W-1:0]   stack_rd_ff;
   logic                       stack_we;
   logic [COLOR_W-1:0]         tour_mem [MAX_EDGES+1];
   logic [COLOR_W-1:0]         tour_rd_ff;
   logic                       tour_we;
   logic [CNT_W-1:0]           tour_raddr;
   logic [CNT_W-1:0]           stack_raddr;
   logic [CNT_W-1:0]           stack_waddr;

   logic [COLOR_W-1:0] ea, eb;
   logic               hit;

   assign ea  = edge_rd_ff[2*COLOR_W-1:COLOR_W];
   assign eb  = edge_rd_ff[COLOR_W-1:0];
   assign hit = !used_ff[j_ff[IDX_W-1:0]] && (ea == here_ff || eb == here_ff);
   assign stack_raddr = sp_ff - CNT_W'(2);
   assign stack_waddr = sp_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[count_ff[IDX_W-1:0]] <= {req_color_a, req_color_b};
      end
      edge_rd_ff <= edge_mem[j_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr[SI_W-1:0]] <= {here_ff, j_ff + CNT_W'(1)};
      end
      stack_rd_ff <= stack_mem[stack_raddr[SI_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (tour_we) begin
         tour_mem[len_ff[SI_W-1:0]] <= here_ff;
      end
      tour_rd_ff <= tour_mem[tour_raddr[SI_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         parity_ff    <= '0;
         start_ff     <= '1;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         parity_ff    <= parity_in;
         start_ff     <= start_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      here_ff       <= here_in;
      j_ff          <= j_in;
      sp_ff         <= sp_in;
      len_ff        <= len_in;
      k_ff          <= k_in;
      prev_ff       <= prev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_to_ff     <= rsp_to_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      parity_in     = parity_ff;
      start_in      = start_ff;
      used_in       = used_ff;
      here_in       = here_ff;
      j_in          = j_ff;
      sp_in         = sp_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_to_in     = rsp_to_ff;
      rsp_last_in   = rsp_last_ff;
      edge_we       = 1'b0;
      stack_we      = 1'b0;
      tour_we       = 1'b0;
      tour_raddr    = k_ff + CNT_W'(1);
      req_ready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_op) begin
                  if (req_color_a != '0 && req_color_b != '0) begin
                     if (count_ff >= MaxCnt) begin
                        ovf_in = 1'b1;
                     end else begin
                        edge_we = 1'b1;
                        used_in[count_ff[IDX_W-1:0]] = 1'b0;
                        count_in = count_ff + CNT_W'(1);
                        parity_in[req_color_a] = parity_in[req_color_a] ^ 1'b1;
                        parity_in[req_color_b] = parity_in[req_color_b] ^ 1'b1;
                        if (req_color_a < start_in) start_in = req_color_a;
                        if (req_color_b < start_in) start_in = req_color_b;
                     end
                  end
               end else begin
                  rsp_from_in = '0;
                  rsp_to_in   = '0;
                  rsp_last_in = 1'b1;
                  if (ovf_ff) begin
                     rsp_status_in = ST_OVERFLOW;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_RESP;
                  end else if (count_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_RESP;
                  end else if (|parity_ff) begin
                     rsp_status_in = ST_LOST;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_RESP;
                  end else begin
                     here_in  = start_ff;
                     j_in     = '0;
                     sp_in    = CNT_W'(1);
                     len_in   = '0;
                     k_in     = '0;
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_FETCH: begin
            if (j_ff < count_ff) begin
               state_in = S_EVAL;
            end else begin
               // pop: record color, resume the entry below
               tour_we = 1'b1;
               len_in  = len_ff + CNT_W'(1);
               sp_in   = sp_ff - CNT_W'(1);
               if (sp_ff == CNT_W'(1)) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_RESTORE;
               end
            end
         end
         S_EVAL: begin
            if (hit) begin
               stack_we = 1'b1;
               used_in[j_ff[IDX_W-1:0]] = 1'b1;
               here_in = (ea == here_ff) ? eb : ea;
               j_in    = '0;
               sp_in   = sp_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
            state_in = S_FETCH;
         end
         S_RESTORE: begin
            here_in  = stack_rd_ff[COLOR_W+CNT_W-1:CNT_W];
            j_in     = stack_rd_ff[CNT_W-1:0];
            state_in = S_FETCH;
         end
         S_CHECK: begin
            tour_raddr = k_ff;
            if (len_ff != count_ff + CNT_W'(1)) begin
               rsp_status_in = ST_LOST;
               rsp_from_in   = '0;
               rsp_to_in     = '0;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_RESP;
            end else begin
               state_in = S_OUT_FIRST;
            end
         end
         S_OUT_FIRST: begin
            prev_in  = tour_rd_ff;
            state_in = S_OUT_RD;
         end
         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_status_in = ST_TOUR;
            rsp_from_in   = prev_ff;
            rsp_to_in     = tour_rd_ff;
            rsp_last_in   = (k_ff + CNT_W'(1) == count_ff);
            prev_in       = tour_rd_ff;
            rsp_valid_in  = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // case done: drop all case state
                  count_in  = '0;
                  ovf_in    = 1'b0;
                  parity_in = '0;
                  start_in  = '1;
                  used_in   = '0;
                  state_in  = S_IDLE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_from_color = rsp_from_ff;
   assign rsp_to_color   = rsp_to_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
